@@ src/process_interval_timer_bank_assert.svh @@
// Assertion macros for the interval timer bank.
`ifndef PROCESS_INTERVAL_TIMER_BANK_ASSERT_SVH
`define PROCESS_INTERVAL_TIMER_BANK_ASSERT_SVH

// Same-cycle implication.
`define PITB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pitb check failed");

// Next-cycle implication.
`define PITB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pitb check failed");

`endif

@@ src/pitb_pkg.sv @@
package pitb_pkg;

   localparam int NUM_PROCS = 8;
   localparam int NUM_KINDS = 3;
   localparam int PROC_W    = 3;
   localparam int IDX_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int CMP_W     = (IDX_W > PROC_W) ? IDX_W : PROC_W;
   localparam int SEQ_W     = NUM_PROCS + 2;
   localparam int POS_W     = $clog2(SEQ_W + 1);

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SET  = 2'd1;
   localparam logic [1:0] FUNC_GET  = 2'd2;

   localparam logic [1:0] KIND_REAL = 2'd0;
   localparam logic [1:0] KIND_VIRT = 2'd1;
   localparam logic [1:0] KIND_PROF = 2'd2;
   localparam logic [1:0] KIND_BAD  = 2'd3;

   localparam logic [1:0] RES_EXPIRED   = 2'd0;
   localparam logic [1:0] RES_TICK_DONE = 2'd1;
   localparam logic [1:0] RES_REPLY     = 2'd2;

   // Operation travelling down the cell row, collecting results as it goes.
   typedef struct packed {
      logic [1:0]           func;
      logic [PROC_W-1:0]    proc;
      logic                 in_kernel;
      logic [1:0]           which;
      logic [31:0]          new_count;
      logic [31:0]          new_interval;
      logic [31:0]          old_count;
      logic [31:0]          old_interval;
      logic [NUM_PROCS-1:0] real_exp;
      logic                 virt_exp;
      logic                 prof_exp;
   } pkt_type;

   typedef struct packed {
      logic [31:0] count;
      logic        expired;
   } adv_type;

   // One tick of a timer: decrement a running count, reload on reaching zero.
   function automatic adv_type advance(input logic [31:0] count, input logic [31:0] interval);
      adv_type r;
      r.expired = (count == 32'd1);
      if (count == 32'd0) begin
         r.count = 32'd0;
      end else if (r.expired) begin
         r.count = interval;
      end else begin
         r.count = count - 32'd1;
      end
      return r;
   endfunction

endpackage

@@ src/pitb_cell.sv @@
module pitb_cell
   import pitb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_id,
   input  logic             in_valid,
   input  pkt_type          in_pkt,
   output logic             out_valid,
   output pkt_type          out_pkt
);

   logic [31:0] count_ff    [NUM_KINDS];
   logic [31:0] count_in    [NUM_KINDS];
   logic [31:0] interval_ff [NUM_KINDS];
   logic [31:0] interval_in [NUM_KINDS];
   logic        valid_ff;
   logic        valid_in;
   pkt_type     pkt_ff;
   pkt_type     pkt_in;
   logic        match;
   logic        real_bit;
   adv_type     adv_real;
   adv_type     adv_virt;
   adv_type     adv_prof;

   assign match    = (CMP_W'(in_pkt.proc) == CMP_W'(cell_id));
   assign adv_real = advance(count_ff[KIND_REAL], interval_ff[KIND_REAL]);
   assign adv_virt = advance(count_ff[KIND_VIRT], interval_ff[KIND_VIRT]);
   assign adv_prof = advance(count_ff[KIND_PROF], interval_ff[KIND_PROF]);

   always_comb begin
      count_in    = count_ff;
      interval_in = interval_ff;
      pkt_in      = in_pkt;
      real_bit    = 1'b0;
      valid_in    = in_valid;
      if (in_valid) begin
         case (in_pkt.func)
            FUNC_TICK: begin
               count_in[KIND_REAL] = adv_real.count;
               real_bit            = adv_real.expired;
               if (match) begin
                  if (!in_pkt.in_kernel) begin
                     count_in[KIND_VIRT] = adv_virt.count;
                     pkt_in.virt_exp     = adv_virt.expired;
                  end
                  count_in[KIND_PROF] = adv_prof.count;
                  pkt_in.prof_exp     = adv_prof.expired;
               end
            end
            FUNC_SET, FUNC_GET: begin
               if (match && in_pkt.which != KIND_BAD) begin
                  pkt_in.old_count    = count_ff[in_pkt.which];
                  pkt_in.old_interval = interval_ff[in_pkt.which];
                  if (in_pkt.func == FUNC_SET) begin
                     count_in[in_pkt.which]    = in_pkt.new_count;
                     interval_in[in_pkt.which] = in_pkt.new_interval;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // expiry flags shift along so that bit 0 ends up with slot 0
      pkt_in.real_exp = (in_pkt.real_exp >> 1)
                      | (NUM_PROCS'(real_bit) << (NUM_PROCS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            count_ff[k]    <= 32'd0;
            interval_ff[k] <= 32'd0;
         end
      end else begin
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         interval_ff <= interval_in;
      end
      pkt_ff <= pkt_in;
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;

endmodule

@@ src/pitb_emit.sv @@
module pitb_emit
   import pitb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pkt_valid,
   input  pkt_type     pkt,
   output logic        done,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_slot,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_count_value,
   output logic [31:0] rsp_interval_value,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_LAST = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   pkt_type          hold_ff, hold_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pos_m2;
   logic             out_free;

   logic        valid_ff, valid_in;
   logic [1:0]  rk_ff, rk_in;
   logic [2:0]  slot_ff, slot_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] ivl_ff, ivl_in;
   logic        last_ff, last_in;

   assign out_free = !valid_ff || rsp_ready;
   assign pos_m2   = pos_ff - POS_W'(2);

   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      seq_in   = seq_ff;
      pos_in   = pos_ff;
      done     = 1'b0;
      valid_in = valid_ff && !rsp_ready;
      rk_in    = rk_ff;
      slot_in  = slot_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      ivl_in   = ivl_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pkt_valid) begin
               hold_in = pkt;
               seq_in  = {pkt.real_exp, pkt.prof_exp, pkt.virt_exp};
               pos_in  = '0;
               case (pkt.func)
                  FUNC_TICK:          state_in = ST_WALK;
                  FUNC_SET, FUNC_GET: state_in = ST_LAST;
                  default:            done     = 1'b1;
               endcase
            end
         end
         ST_WALK: begin
            // virtual, profiling, then real timers by ascending slot
            if (!seq_ff[0] || out_free) begin
               seq_in = seq_ff >> 1;
               pos_in = pos_ff + POS_W'(1);
               if (seq_ff[0]) begin
                  valid_in = 1'b1;
                  rk_in    = RES_EXPIRED;
                  cnt_in   = 32'd0;
                  ivl_in   = 32'd0;
                  last_in  = 1'b0;
                  if (pos_ff == POS_W'(0)) begin
                     slot_in = hold_ff.proc;
                     kind_in = KIND_VIRT;
                  end else if (pos_ff == POS_W'(1)) begin
                     slot_in = hold_ff.proc;
                     kind_in = KIND_PROF;
                  end else begin
                     slot_in = 3'(pos_m2);
                     kind_in = KIND_REAL;
                  end
               end
               if (pos_ff == POS_W'(SEQ_W - 1)) begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               valid_in = 1'b1;
               slot_in  = hold_ff.proc;
               last_in  = 1'b1;
               if (hold_ff.func == FUNC_TICK) begin
                  rk_in   = RES_TICK_DONE;
                  kind_in = KIND_REAL;
                  cnt_in  = 32'd0;
                  ivl_in  = 32'd0;
               end else begin
                  rk_in   = RES_REPLY;
                  kind_in = hold_ff.which;
                  cnt_in  = hold_ff.old_count;
                  ivl_in  = hold_ff.old_interval;
               end
               state_in = ST_IDLE;
               done     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      hold_ff <= hold_in;
      seq_ff  <= seq_in;
      pos_ff  <= pos_in;
      rk_ff   <= rk_in;
      slot_ff <= slot_in;
      kind_ff <= kind_in;
      cnt_ff  <= cnt_in;
      ivl_ff  <= ivl_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = rk_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_count_value    = cnt_ff;
   assign rsp_interval_value = ivl_ff;
   assign rsp_last           = last_ff;

endmodule

@@ src/process_interval_timer_bank.sv @@
// Per-process interval timer bank: real, virtual and profiling timers for each process slot.
// Request channel (req_*): one operation per transfer - tick, set or get.
// Response channel (rsp_*): expiries of a tick, then a tick-done record with rsp_last set;
// set and get give one reply (old or current count and interval) with rsp_last set.
// Operation code 3 is dropped without any response.
// One operation is in flight at a time; req_ready is low from acceptance until the
// final response is loaded into the output register.
// The operation walks a row of NUM_PROCS cells, one cell per cycle, each holding one
// slot's timers. The response stage then steps through NUM_PROCS + 2 expiry positions
// at one per cycle, except that an expiry waits while the output register is still full.
// A stalled receiver holds rsp_* steady and stops the walk at the next expiry; the next
// request may be taken while the final response still waits in the output register.
// Reset (synchronous, active high) clears every count and interval, disarming all
// timers, and empties both channels; req_ready stays low while reset is high.
module process_interval_timer_bank
   import pitb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_proc,
   input  logic        req_in_kernel,
   input  logic [1:0]  req_which,
   input  logic [31:0] req_new_count,
   input  logic [31:0] req_new_interval,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_slot,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_count_value,
   output logic [31:0] rsp_interval_value,
   output logic        rsp_last
);

   logic    busy_ff, busy_in;
   logic    accept;
   logic    done;
   logic    chain_valid [NUM_PROCS+1];
   pkt_type chain_pkt   [NUM_PROCS+1];

   assign req_ready = !busy_ff && !reset;
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      chain_valid[0]            = accept;
      chain_pkt[0]              = '0;
      chain_pkt[0].func         = req_func;
      chain_pkt[0].proc         = req_proc;
      chain_pkt[0].in_kernel    = req_in_kernel;
      chain_pkt[0].which        = req_which;
      chain_pkt[0].new_count    = req_new_count;
      chain_pkt[0].new_interval = req_new_interval;
   end

   for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
      pitb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (IDX_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_pkt    (chain_pkt[i]),
         .out_valid (chain_valid[i+1]),
         .out_pkt   (chain_pkt[i+1])
      );
   end

   pitb_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .pkt_valid          (chain_valid[NUM_PROCS]),
      .pkt                (chain_pkt[NUM_PROCS]),
      .done               (done),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_slot           (rsp_slot),
      .rsp_kind           (rsp_kind),
      .rsp_count_value    (rsp_count_value),
      .rsp_interval_value (rsp_interval_value),
      .rsp_last           (rsp_last)
   );

`include "process_interval_timer_bank_assert.svh"

   `PITB_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)
   `PITB_ASSERT_NOW(a_chain_busy, clock, reset, chain_valid[NUM_PROCS], busy_ff)
   `PITB_ASSERT_NOW(a_done_busy, clock, reset, done, busy_ff && !accept)

endmodule

@@ tb/sv/tb_process_interval_timer_bank.sv @@
`timescale 1ns / 1ps

module tb_process_interval_timer_bank
   import pitb_pkg::*;
;

   localparam logic [1:0]  FUNC_NONE    = 2'd3;   // undefined code, dropped by the block
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam int          RANDOM_ITEMS = 128;
   localparam int          CALM_ITEMS   = 30;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  proc;
      logic        in_kernel;
      logic [1:0]  which;
      logic [31:0] new_count;
      logic [31:0] new_interval;
      logic        fixed;        // reply typed in below rather than predicted
      logic [31:0] fix_count;
      logic [31:0] fix_interval;
   } req_row_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  slot;
      logic [1:0]  kind;
      logic [31:0] count_value;
      logic [31:0] interval_value;
      logic        last;
   } rsp_rec_type;

   localparam int N_DIRECTED = 22;
   localparam req_row_type DIRECTED [0:N_DIRECTED-1] = '{
      // state straight after reset
      '{FUNC_GET,  3'd0, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0},
      '{FUNC_GET,  3'd7, 1'b0, KIND_PROF, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0},
      '{FUNC_TICK, 3'd0, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      // bad timer kind: nothing written, zero reply; then an all-ones write read back
      '{FUNC_SET,  3'd2, 1'b0, KIND_BAD,  ALL_ONES, ALL_ONES, 1'b1, 32'd0, 32'd0},
      '{FUNC_GET,  3'd2, 1'b1, KIND_BAD,  32'd0, 32'd0, 1'b1, 32'd0, 32'd0},
      '{FUNC_SET,  3'd7, 1'b0, KIND_REAL, ALL_ONES, ALL_ONES, 1'b1, 32'd0, 32'd0},
      '{FUNC_GET,  3'd7, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b1, ALL_ONES, ALL_ONES},
      // arm timers close to expiry, one-shot and periodic
      '{FUNC_SET,  3'd3, 1'b0, KIND_VIRT, 32'd1, 32'd0, 1'b1, 32'd0, 32'd0},
      '{FUNC_SET,  3'd3, 1'b0, KIND_PROF, 32'd1, 32'd2, 1'b1, 32'd0, 32'd0},
      '{FUNC_SET,  3'd1, 1'b0, KIND_REAL, 32'd1, 32'd1, 1'b1, 32'd0, 32'd0},
      '{FUNC_SET,  3'd5, 1'b0, KIND_REAL, 32'd2, 32'd0, 1'b1, 32'd0, 32'd0},
      '{FUNC_SET,  3'd0, 1'b0, KIND_VIRT, 32'd1, 32'd1, 1'b1, 32'd0, 32'd0},
      // in kernel: virtual held, profiling still runs
      '{FUNC_TICK, 3'd3, 1'b1, KIND_REAL, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      '{FUNC_TICK, 3'd3, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      '{FUNC_GET,  3'd3, 1'b0, KIND_VIRT, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      '{FUNC_GET,  3'd3, 1'b0, KIND_PROF, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      '{FUNC_NONE, 3'd4, 1'b1, KIND_BAD,  ALL_ONES, ALL_ONES, 1'b0, 32'd0, 32'd0},
      '{FUNC_TICK, 3'd0, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      // disarm a running timer
      '{FUNC_SET,  3'd7, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      '{FUNC_SET,  3'd4, 1'b0, KIND_PROF, ALL_ONES, 32'd0, 1'b1, 32'd0, 32'd0},
      '{FUNC_TICK, 3'd4, 1'b1, KIND_REAL, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
      '{FUNC_GET,  3'd7, 1'b0, KIND_REAL, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [2:0]  req_proc;
   logic        req_in_kernel;
   logic [1:0]  req_which;
   logic [31:0] req_new_count;
   logic [31:0] req_new_interval;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_slot;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_count_value;
   logic [31:0] rsp_interval_value;
   logic        rsp_last;

   logic [31:0] tmr_count  [NUM_PROCS*NUM_KINDS] = '{default: '0};
   logic [31:0] tmr_reload [NUM_PROCS*NUM_KINDS] = '{default: '0};
   rsp_rec_type pending_rsp[$];

   bit          quiet_tail = 1'b0;
   int          mismatches = 0;
   int          n_tick = 0, n_set = 0, n_get = 0, n_drop = 0;
   int          n_rsp = 0, n_expiry = 0;
   int unsigned idle_cycles = 0;

   process_interval_timer_bank u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_proc           (req_proc),
      .req_in_kernel      (req_in_kernel),
      .req_which          (req_which),
      .req_new_count      (req_new_count),
      .req_new_interval   (req_new_interval),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_slot           (rsp_slot),
      .rsp_kind           (rsp_kind),
      .rsp_count_value    (rsp_count_value),
      .rsp_interval_value (rsp_interval_value),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- timer model

   function automatic void note_rsp(input logic [1:0] rk, input logic [2:0] slot,
                                    input logic [1:0] kind, input logic [31:0] cnt,
                                    input logic [31:0] ivl);
      rsp_rec_type r;
      r.result_kind    = rk;
      r.slot           = slot;
      r.kind           = kind;
      r.count_value    = cnt;
      r.interval_value = ivl;
      r.last           = (rk != RES_EXPIRED);
      pending_rsp.push_back(r);
   endfunction

   // One tick of a single timer; 1 when it expired and reloaded.
   function automatic bit tick_timer(input int idx);
      if (tmr_count[idx] == 32'd0) return 1'b0;
      tmr_count[idx] = tmr_count[idx] - 32'd1;
      if (tmr_count[idx] != 32'd0) return 1'b0;
      tmr_count[idx] = tmr_reload[idx];
      return 1'b1;
   endfunction

   function automatic void timer_bank_step(input req_row_type r);
      int base;
      int idx;
      base = int'(r.proc) * NUM_KINDS;
      case (r.func)
         FUNC_TICK: begin
            if (int'(r.proc) < NUM_PROCS) begin
               if (!r.in_kernel && tick_timer(base + int'(KIND_VIRT)))
                  note_rsp(RES_EXPIRED, r.proc, KIND_VIRT, 32'd0, 32'd0);
               if (tick_timer(base + int'(KIND_PROF)))
                  note_rsp(RES_EXPIRED, r.proc, KIND_PROF, 32'd0, 32'd0);
            end
            for (int s = 0; s < NUM_PROCS; s++) begin
               if (tick_timer(s * NUM_KINDS + int'(KIND_REAL)))
                  note_rsp(RES_EXPIRED, 3'(s), KIND_REAL, 32'd0, 32'd0);
            end
            note_rsp(RES_TICK_DONE, r.proc, KIND_REAL, 32'd0, 32'd0);
         end
         FUNC_SET, FUNC_GET: begin
            if (int'(r.proc) < NUM_PROCS && r.which != KIND_BAD) begin
               idx = base + int'(r.which);
               note_rsp(RES_REPLY, r.proc, r.which, tmr_count[idx], tmr_reload[idx]);
               if (r.func == FUNC_SET) begin
                  tmr_count[idx]  = r.new_count;
                  tmr_reload[idx] = r.new_interval;
               end
            end else begin
               note_rsp(RES_REPLY, r.proc, r.which, 32'd0, 32'd0);
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_row_type random_row();
      req_row_type r;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.func = FUNC_TICK;
      else if (pick < 70) r.func = FUNC_SET;
      else if (pick < 92) r.func = FUNC_GET;
      else                r.func = FUNC_NONE;
      r.proc      = 3'($urandom_range(0, 7));
      r.in_kernel = 1'($urandom_range(0, 1));
      r.which     = ($urandom_range(0, 9) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
      // mostly short counts so that ticks actually reach expiry
      pick = $urandom_range(0, 99);
      if (pick < 70)      r.new_count = $urandom_range(0, 4);
      else if (pick < 85) r.new_count = $urandom_range(5, 12);
      else                r.new_count = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 80)      r.new_interval = $urandom_range(0, 3);
      else                r.new_interval = $urandom();
      r.fixed        = 1'b0;
      r.fix_count    = 32'd0;
      r.fix_interval = 32'd0;
      return r;
   endfunction

   task automatic send_req(input req_row_type r, input bit idle_ok);
      rsp_rec_type typed;
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= r.func;
      req_proc         <= r.proc;
      req_in_kernel    <= r.in_kernel;
      req_which        <= r.which;
      req_new_count    <= r.new_count;
      req_new_interval <= r.new_interval;
      do @(posedge clock); while (!req_ready);
      timer_bank_step(r);
      if (r.fixed) begin
         // model still updated; swap its reply for the hand-written one
         typed = pending_rsp.pop_back();
         typed.count_value    = r.fix_count;
         typed.interval_value = r.fix_interval;
         pending_rsp.push_back(typed);
      end
      case (r.func)
         FUNC_TICK: n_tick++;
         FUNC_SET:  n_set++;
         FUNC_GET:  n_get++;
         default:   n_drop++;
      endcase
   endtask

   initial begin
      int          counted;
      req_row_type row;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_TICK;
      req_proc         = '0;
      req_in_kernel    = 1'b0;
      req_which        = KIND_REAL;
      req_new_count    = '0;
      req_new_interval = '0;
      counted          = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_req(DIRECTED[i], 1'b1);

      while (counted < RANDOM_ITEMS) begin
         row = random_row();
         quiet_tail = (counted >= RANDOM_ITEMS - CALM_ITEMS);
         send_req(row, !quiet_tail);
         counted++;
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Requests: %0d ticks, %0d sets, %0d gets, %0d undefined codes",
               n_tick, n_set, n_get, n_drop);
      $display("Responses checked: %0d, of which %0d timer expiries", n_rsp, n_expiry);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // receiver: random back-pressure bursts, none in the closing stretch
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (rsp_result_kind == RES_EXPIRED) n_expiry++;
         if (pending_rsp.size() == 0) begin
            $error("response transfer with nothing outstanding (kind %0d, slot %0d)",
                   rsp_result_kind, rsp_slot);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("rsp_result_kind", 32'(want.result_kind), 32'(rsp_result_kind));
            check_field("rsp_slot", 32'(want.slot), 32'(rsp_slot));
            check_field("rsp_kind", 32'(want.kind), 32'(rsp_kind));
            check_field("rsp_count_value", want.count_value, rsp_count_value);
            check_field("rsp_interval_value", want.interval_value, rsp_interval_value);
            check_field("rsp_last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // watchdog: any transfer on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
                  idle_cycles, pending_rsp.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ process_interval_timer_bank.f @@
+incdir+src
src/pitb_pkg.sv
src/pitb_cell.sv
src/pitb_emit.sv
src/process_interval_timer_bank.sv
tb/sv/tb_process_interval_timer_bank.sv
